// ===== hw/rtl/lfse_pkg.sv =====
package lfse_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SPEED_SCALE       = 3'd0;
    localparam logic [2:0] REG_RATIO_EXPONENT    = 3'd1;
    localparam logic [2:0] REG_GAUSS_WIDTH       = 3'd2;
    localparam logic [2:0] REG_DILUTION_GAIN     = 3'd3;
    localparam logic [2:0] REG_TEMP_EXPONENT     = 3'd4;
    localparam logic [2:0] REG_PRESSURE_EXPONENT = 3'd5;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    // log2 of y/2^30 for y in [2^30, 2^31], q0.24, bit-exact squaring method
    function automatic logic [63:0] exact_log2(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] ip;
        y  = y_in;
        r  = 64'd0;
        ip = 64'd0;
        if (y >= 64'h8000_0000) begin
            ip = 64'd1;
            y  = y >> 1;
        end
        for (int b = 0; b < 25; b++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= 64'h8000_0000) begin
                r = r | 64'd1;
                y = y >> 1;
            end
        end
        return (ip << 24) + ((r + 64'd1) >> 1);
    endfunction

    // log2(1 + i/2^abits) in q0.24
    function automatic logic [24:0] lg_entry(input int i, input int abits);
        logic [63:0] y;
        y = (64'd1 << 30) + (64'(i) << (30 - abits));
        return 25'(exact_log2(y));
    endfunction

    // 2^(i/2^abits) in q1.30 from a truncated series
    function automatic logic [31:0] ex_entry(input int i, input int abits);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        t    = (64'(i) * LN2_Q32) >> abits;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * t) >> 32) / 64'(k);
            sum  = sum + term;
        end
        return 32'((sum + 64'd2) >> 2);
    endfunction

    // log2(300) and log2(101300) in q.24
    localparam logic [29:0] LOG2_TREF = 30'((64'd8 << 24) + exact_log2(64'd300 << 22));
    localparam logic [29:0] LOG2_PREF =
        30'((64'd16 << 24) + exact_log2(64'd101300 << 14));

endpackage

// ===== hw/rtl/lfse_log2.sv =====
module lfse_log2 #(
    parameter int LUT_ADDR_BITS = 8,
    parameter int XW            = 29
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [XW-1:0] x,
    output logic [29:0]   lg_out
);
    import lfse_pkg::*;

    localparam int N  = 1 << LUT_ADDR_BITS;
    localparam int SH = 31 - LUT_ADDR_BITS;

    logic [24:0] lg_rom [N+1];

    for (genvar gi = 0; gi <= N; gi++) begin : g_rom
        assign lg_rom[gi] = lg_entry(gi, LUT_ADDR_BITS);
    end

    logic [4:0]               e_next;
    logic [31:0]              m_next;
    logic [4:0]               e_reg;
    logic [LUT_ADDR_BITS-1:0] idx_reg;
    logic [SH-1:0]            rem_reg;
    logic [4:0]               e2_reg;
    logic [SH-1:0]            rem2_reg;
    logic [24:0]              lo_reg;
    logic [24:0]              diff_reg;
    logic [LUT_ADDR_BITS:0]   idx_ext;
    logic [24+SH:0]           ip_prod;

    // leading one and normalise to bit 31
    always_comb begin
        e_next = 5'd0;
        for (int i = 0; i < XW; i++) begin
            if (x[i]) begin
                e_next = 5'(i);
            end
        end
        m_next = 32'(x) << (5'd31 - e_next);
    end

    assign idx_ext = {1'b0, idx_reg};
    assign ip_prod = (25 + SH)'(diff_reg) * (25 + SH)'(rem2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg    <= e_next;
            idx_reg  <= m_next[30 -: LUT_ADDR_BITS];
            rem_reg  <= m_next[SH-1:0];
            e2_reg   <= e_reg;
            rem2_reg <= rem_reg;
            lo_reg   <= lg_rom[idx_ext];
            diff_reg <= lg_rom[idx_ext + 1'b1] - lg_rom[idx_ext];
            lg_out   <= {e2_reg, 24'd0} + 30'(lo_reg) + 30'(ip_prod >> SH);
        end
    end

endmodule

// ===== hw/rtl/laminar_flame_speed_eval_top.sv =====
// laminar flame speed evaluator: per beat takes pressure, unburnt temperature, equivalence
// ratio and egr fraction and returns su = w * phi^eta * exp(-xi*(phi-1.075)^2) * (t/300)^alpha
// * (p/101300)^beta * max(1-f*egr, 0) in unsigned q4.20, saturating with a flag. all factors
// are summed in the log2 domain (five table-interpolated log2 units) and one exp2 unit forms
// the result. a ten-stage pipeline accepts one beat per clock. the whole pipeline stalls only
// while the output register holds a beat that is not taken. configuration writes land at once
// and are meant for idle periods only.
module laminar_flame_speed_eval_top #(
    parameter int LUT_ADDR_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_pressure_pa,
    input  logic [15:0] s_unburnt_temp,
    input  logic [15:0] s_equivalence_ratio,
    input  logic [15:0] s_egr_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_flame_speed,
    output logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wr_data
);
    import lfse_pkg::*;

    localparam int N    = 1 << LUT_ADDR_BITS;
    localparam int ESH  = 32 - LUT_ADDR_BITS;
    localparam int DEPTH = 10;

    localparam logic signed [31:0] OFF_SCALE = 32'sd335544320;  // 20 in q.24
    localparam logic signed [31:0] OFF_FAC   = 32'sd469762048;  // 28 in q.24
    localparam logic signed [31:0] OFF_PHI   = 32'sd201326592;  // 12 in q.24
    localparam logic signed [31:0] OFF_T     = 32'sd67108864 + 32'(LOG2_TREF);
    localparam logic signed [31:0] OFF_P     = 32'(LOG2_PREF);
    localparam logic signed [29:0] PHI_PEAK  = 30'sd18035507;   // 1.075 in q.24
    localparam logic signed [25:0] LOG2E     = 26'sd24204406;
    localparam logic signed [39:0] G_CLAMP   = 40'sh40_0000_0000;
    localparam logic signed [59:0] K_BIAS    = 60'sd20 <<< 40;

    typedef struct packed {
        logic force_zero;
        logic force_sat;
        logic t_zero;
        logic p_zero;
    } flags_t;

    // configuration registers
    logic [23:0]        speed_scale_reg;
    logic signed [23:0] ratio_exp_reg;
    logic signed [23:0] gauss_width_reg;
    logic [15:0]        dil_gain_reg;
    logic signed [23:0] temp_exp_reg;
    logic signed [23:0] press_exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_scale_reg <= 24'd442499;
            ratio_exp_reg   <= 24'sd9830;
            gauss_width_reg <= 24'sd339476;
            dil_gain_reg    <= 16'd9421;
            temp_exp_reg    <= 24'sd131072;
            press_exp_reg   <= -24'sd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SPEED_SCALE:       speed_scale_reg <= cfg_wr_data;
                REG_RATIO_EXPONENT:    ratio_exp_reg   <= cfg_wr_data;
                REG_GAUSS_WIDTH:       gauss_width_reg <= cfg_wr_data;
                REG_DILUTION_GAIN:     dil_gain_reg    <= cfg_wr_data[15:0];
                REG_TEMP_EXPONENT:     temp_exp_reg    <= cfg_wr_data;
                REG_PRESSURE_EXPONENT: press_exp_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // one enable for the whole pipe, valid bits travel alongside
    logic             pipe_en;
    logic [DEPTH-1:0] vld_reg;

    assign pipe_en = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // stage 1: special cases, dilution product, ratio offset
    flags_t             fl_next;
    flags_t             fl_reg [DEPTH-1];
    logic [31:0]        prod_next;
    logic               phi_zero;
    logic               sat_case;
    logic               zero_case;
    logic [23:0]        p1_reg;
    logic [15:0]        t1_reg;
    logic [15:0]        phi1_reg;
    logic [31:0]        prod1_reg;
    logic signed [29:0] d1_reg;

    always_comb begin
        prod_next = 32'(dil_gain_reg) * 32'(s_egr_fraction);
        phi_zero  = (s_equivalence_ratio == 16'd0);
        sat_case  = ((s_unburnt_temp == 16'd0) && (temp_exp_reg < 0))
                 || ((s_pressure_pa == 24'd0) && (press_exp_reg < 0));
        zero_case = ((s_unburnt_temp == 16'd0) && (temp_exp_reg > 0))
                 || ((s_pressure_pa == 24'd0) && (press_exp_reg > 0))
                 || (speed_scale_reg == 24'd0)
                 || (prod_next >= (32'd1 << 28));
        fl_next.force_zero = phi_zero || (!sat_case && zero_case);
        fl_next.force_sat  = !phi_zero && sat_case;
        fl_next.t_zero     = (s_unburnt_temp == 16'd0);
        fl_next.p_zero     = (s_pressure_pa == 24'd0);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fl_reg[0] <= fl_next;
            for (int i = 1; i < DEPTH - 1; i++) begin
                fl_reg[i] <= fl_reg[i-1];
            end
            p1_reg    <= s_pressure_pa;
            t1_reg    <= s_unburnt_temp;
            phi1_reg  <= s_equivalence_ratio;
            prod1_reg <= prod_next;
            d1_reg    <= $signed({2'b00, s_equivalence_ratio, 12'd0}) - PHI_PEAK;
        end
    end

    // stages 2 to 4: five log2 units
    logic [28:0] fac1;
    logic [29:0] lg_scale;
    logic [29:0] lg_fac;
    logic [29:0] lg_phi;
    logic [29:0] lg_t;
    logic [29:0] lg_p;

    assign fac1 = 29'((32'd1 << 28) - prod1_reg);

    lfse_log2 #(.LUT_ADDR_BITS(LUT_ADDR_BITS), .XW(24)) u_log_scale (
        .aclk(aclk), .en(pipe_en), .x(speed_scale_reg), .lg_out(lg_scale));
    lfse_log2 #(.LUT_ADDR_BITS(LUT_ADDR_BITS), .XW(29)) u_log_fac (
        .aclk(aclk), .en(pipe_en), .x(fac1), .lg_out(lg_fac));
    lfse_log2 #(.LUT_ADDR_BITS(LUT_ADDR_BITS), .XW(16)) u_log_phi (
        .aclk(aclk), .en(pipe_en), .x(phi1_reg), .lg_out(lg_phi));
    lfse_log2 #(.LUT_ADDR_BITS(LUT_ADDR_BITS), .XW(16)) u_log_t (
        .aclk(aclk), .en(pipe_en), .x(t1_reg), .lg_out(lg_t));
    lfse_log2 #(.LUT_ADDR_BITS(LUT_ADDR_BITS), .XW(24)) u_log_p (
        .aclk(aclk), .en(pipe_en), .x(p1_reg), .lg_out(lg_p));

    // stages 2 to 6: gaussian term, clamped and scaled by log2(e)
    logic [27:0]        d_mag;
    logic [55:0]        sq2_reg;
    logic signed [63:0] gprod3_reg;
    logic signed [39:0] g4_reg;
    logic signed [63:0] g_shift;
    logic [44:0]        gl5_reg;
    logic signed [45:0] gh5_reg;

    assign d_mag   = d1_reg[29] ? 28'(-d1_reg) : 28'(d1_reg);
    assign g_shift = gprod3_reg >>> 16;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq2_reg    <= 56'(d_mag) * 56'(d_mag);
            gprod3_reg <= 64'(gauss_width_reg) * $signed({32'd0, sq2_reg[55:24]});
            if (g_shift > 64'(G_CLAMP)) begin
                g4_reg <= G_CLAMP;
            end else if (g_shift < -64'(G_CLAMP)) begin
                g4_reg <= -G_CLAMP;
            end else begin
                g4_reg <= 40'(g_shift);
            end
            // split product, low half unsigned, high half signed
            gl5_reg <= 45'(g4_reg[19:0]) * 45'(LOG2E);
            gh5_reg <= 46'($signed(g4_reg[39:20])) * 46'(LOG2E);
        end
    end

    // stage 5: exponent products
    logic signed [31:0] l_scale;
    logic signed [31:0] l_fac;
    logic signed [31:0] l_phi;
    logic signed [31:0] l_t;
    logic signed [31:0] l_p;
    logic signed [59:0] base5_reg;
    logic signed [55:0] eta5_reg;
    logic signed [55:0] tp5_reg;
    logic signed [55:0] pp5_reg;

    assign l_scale = $signed({2'b00, lg_scale}) - OFF_SCALE;
    assign l_fac   = $signed({2'b00, lg_fac}) - OFF_FAC;
    assign l_phi   = $signed({2'b00, lg_phi}) - OFF_PHI;
    assign l_t     = $signed({2'b00, lg_t}) - OFF_T;
    assign l_p     = $signed({2'b00, lg_p}) - OFF_P;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            base5_reg <= (60'(l_scale) + 60'(l_fac)) <<< 16;
            eta5_reg  <= 56'(ratio_exp_reg) * 56'(l_phi);
            tp5_reg   <= fl_reg[3].t_zero ? 56'sd0 : 56'(temp_exp_reg) * 56'(l_t);
            pp5_reg   <= fl_reg[3].p_zero ? 56'sd0 : 56'(press_exp_reg) * 56'(l_p);
        end
    end

    // stages 6 and 7: sum in q.40, bias to the q4.20 result exponent
    logic signed [63:0] gfull;
    logic signed [59:0] sum6_reg;
    logic signed [59:0] gterm6_reg;
    logic signed [59:0] k7_reg;

    assign gfull = (64'(gh5_reg) <<< 20) + $signed({19'd0, gl5_reg});

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sum6_reg   <= base5_reg + 60'(eta5_reg) + 60'(tp5_reg) + 60'(pp5_reg);
            gterm6_reg <= 60'(gfull >>> 8);
            k7_reg     <= sum6_reg - gterm6_reg + K_BIAS;
        end
    end

    // stage 8: exp2 table lookup, range checks
    logic [31:0]              ex_rom [N+1];
    logic signed [19:0]       n7;
    logic [31:0]              f7;
    logic [LUT_ADDR_BITS:0]   eidx;
    logic [31:0]              ex_lo8_reg;
    logic [31:0]              ex_diff8_reg;
    logic [ESH-1:0]           rem8_reg;
    logic                     ovf8_reg;
    logic                     unf8_reg;
    logic [4:0]               sh8_reg;

    for (genvar gi = 0; gi <= N; gi++) begin : g_ex_rom
        assign ex_rom[gi] = ex_entry(gi, LUT_ADDR_BITS);
    end

    assign n7   = k7_reg[59:40];
    assign f7   = k7_reg[39:8];
    assign eidx = {1'b0, f7[31 -: LUT_ADDR_BITS]};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ex_lo8_reg   <= ex_rom[eidx];
            ex_diff8_reg <= ex_rom[eidx + 1'b1] - ex_rom[eidx];
            rem8_reg     <= f7[ESH-1:0];
            ovf8_reg     <= (n7 >= 20'sd24);
            unf8_reg     <= (n7 < -20'sd1);
            sh8_reg      <= 5'd30 - n7[4:0];
        end
    end

    // stage 9: interpolation
    logic [31+ESH:0] eprod;
    logic [32:0]     mant9_reg;
    logic            ovf9_reg;
    logic            unf9_reg;
    logic [4:0]      sh9_reg;

    assign eprod = (32 + ESH)'(ex_diff8_reg) * (32 + ESH)'(rem8_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mant9_reg <= 33'(ex_lo8_reg) + 33'(eprod >> ESH);
            ovf9_reg  <= ovf8_reg;
            unf9_reg  <= unf8_reg;
            sh9_reg   <= sh8_reg;
        end
    end

    // stage 10: round half up, saturate, output register
    logic [33:0] v_round;
    logic [23:0] speed_next;
    logic        sat_next;
    flags_t      fl9;

    assign fl9     = fl_reg[DEPTH-2];
    assign v_round = (34'(mant9_reg) + (34'd1 << (sh9_reg - 5'd1))) >> sh9_reg;

    always_comb begin
        speed_next = v_round[23:0];
        sat_next   = 1'b0;
        if (fl9.force_zero) begin
            speed_next = 24'd0;
        end else if (fl9.force_sat || ovf9_reg) begin
            speed_next = '1;
            sat_next   = 1'b1;
        end else if (unf9_reg) begin
            speed_next = 24'd0;
        end else if (v_round > 34'hFF_FFFF) begin
            speed_next = '1;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_flame_speed <= speed_next;
            m_saturated   <= sat_next;
        end
    end

    // a clipped result always reads full scale
    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_flame_speed == 24'hFF_FFFF)
        else $error("saturated result not at full scale");

    // a stall freezes every valid bit
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // an accepted beat occupies the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

endmodule

// ===== dv/lfse_checker.sv =====
`timescale 1ns / 100ps

module lfse_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_pressure_pa,
    input  logic [15:0] s_unburnt_temp,
    input  logic [15:0] s_equivalence_ratio,
    input  logic [15:0] s_egr_fraction,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_flame_speed,
    input  logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wr_data,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output int          sat_seen
);
    import lfse_pkg::*;

    localparam int ABITS = 8;
    localparam int NTAB = 1 << ABITS;
    localparam int LG_SH = 31 - ABITS;
    localparam int EX_SH = 32 - ABITS;
    localparam longint LOG2E_Q24 = 24204406;
    localparam longint PHI_PEAK_Q24 = 18035507;
    localparam longint GAUSS_CLAMP = longint'(1) << 38;
    localparam logic [63:0] LN2_FRAC_Q32 = 64'd2977044472;

    typedef struct packed {
        logic [23:0] speed;
        logic        sat;
    } flame_t;

    logic [63:0] log_lut [0:NTAB];
    logic [63:0] pow_lut [0:NTAB];
    longint      log2_t300;
    longint      log2_p1013;

    // register copies
    logic [23:0] w_scale;
    longint      eta;
    longint      xi;
    logic [15:0] dil_gain;
    longint      alpha;
    longint      beta;

    flame_t      speeds_due[$];

    // log2 of y/2^30, y in [2^30, 2^31], q0.24 by repeated squaring
    function automatic logic [63:0] log2_by_squaring(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] ip;
        y  = y_in;
        r  = 0;
        ip = 0;
        if (y >= (64'd1 << 31)) begin
            ip = 1;
            y  = y >> 1;
        end
        for (int b = 0; b < 25; b++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd1 << 31)) begin
                r = r | 64'd1;
                y = y >> 1;
            end
        end
        return (ip << 24) + ((r + 64'd1) >> 1);
    endfunction

    initial begin
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        for (int i = 0; i <= NTAB; i++) begin
            log_lut[i] = log2_by_squaring((64'd1 << 30) + (64'(i) << (30 - ABITS)));
            t    = (64'(i) * LN2_FRAC_Q32) >> ABITS;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * t) >> 32) / 64'(k);
                sum  = sum + term;
            end
            pow_lut[i] = (sum + 64'd2) >> 2;
        end
        log2_t300  = (longint'(8) << 24) + longint'(log2_by_squaring(64'd300 << 22));
        log2_p1013 = (longint'(16) << 24) + longint'(log2_by_squaring(64'd101300 << 14));
    end

    // log2 of x/2^q, x nonzero, signed q.24
    function automatic longint log2_fixed(input logic [63:0] x, input int q);
        int          e;
        logic [63:0] m;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] v;
        e = 63;
        while (e > 0 && !x[e])
            e--;
        m   = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        idx = (m >> LG_SH) & 64'(NTAB - 1);
        rem = m & ((64'd1 << LG_SH) - 1);
        v   = log_lut[idx] + (((log_lut[idx + 1] - log_lut[idx]) * rem) >> LG_SH);
        return longint'(e - q) * (longint'(1) << 24) + longint'(v);
    endfunction

    // 2^(f/2^32) as q1.30
    function automatic logic [63:0] exp2_fixed(input logic [63:0] f);
        logic [63:0] idx;
        logic [63:0] rem;
        idx = (f >> EX_SH) & 64'(NTAB - 1);
        rem = f & ((64'd1 << EX_SH) - 1);
        return pow_lut[idx] + (((pow_lut[idx + 1] - pow_lut[idx]) * rem) >> EX_SH);
    endfunction

    function automatic flame_t flame_speed_of(input logic [23:0] p, input logic [15:0] t,
                                              input logic [15:0] phi, input logic [15:0] egr);
        flame_t      r;
        logic [63:0] prod;
        logic [63:0] sq;
        logic [63:0] mant;
        logic [63:0] v;
        longint      lsum;
        longint      d;
        longint      g;
        longint      k;
        longint      n;
        r = '0;
        if (phi == 0)
            return r;
        if ((t == 0 && alpha < 0) || (p == 0 && beta < 0)) begin
            r.speed = '1;
            r.sat   = 1'b1;
            return r;
        end
        if ((t == 0 && alpha > 0) || (p == 0 && beta > 0))
            return r;
        if (w_scale == 0)
            return r;
        prod = 64'(dil_gain) * 64'(egr);
        if (prod >= (64'd1 << 28))
            return r;

        lsum = log2_fixed(64'(w_scale), 20) * 65536;
        lsum += log2_fixed((64'd1 << 28) - prod, 28) * 65536;
        lsum += eta * log2_fixed(64'(phi), 12);

        // gauss term around the peak ratio
        d  = longint'(phi) * 4096 - PHI_PEAK_Q24;
        sq = 64'(d * d) >> 24;
        g  = (xi * longint'(sq)) >>> 16;
        if (g > GAUSS_CLAMP)
            g = GAUSS_CLAMP;
        if (g < -GAUSS_CLAMP)
            g = -GAUSS_CLAMP;
        lsum -= (g * LOG2E_Q24) >>> 8;

        if (t != 0)
            lsum += alpha * (log2_fixed(64'(t), 4) - log2_t300);
        if (p != 0)
            lsum += beta * (log2_fixed(64'(p), 0) - log2_p1013);

        k = lsum + (longint'(20) << 40);
        n = k >>> 40;
        if (n >= 24) begin
            r.speed = '1;
            r.sat   = 1'b1;
            return r;
        end
        if (n < -1)
            return r;
        mant = exp2_fixed((64'(k) & ((64'd1 << 40) - 1)) >> 8);
        v    = (mant + (64'd1 << (29 - n))) >> (30 - n);
        if (v > 64'hFF_FFFF) begin
            r.speed = '1;
            r.sat   = 1'b1;
            return r;
        end
        r.speed = v[23:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches   = 0;
        results_seen = 0;
        sat_seen     = 0;
        outstanding  = 0;
    end

    // inputs only move on rising edges, so the falling edge sees what the next edge takes
    always @(negedge aclk) begin
        flame_t want;
        if (!aresetn) begin
            w_scale  = 24'd442499;
            eta      = 9830;
            xi       = 339476;
            dil_gain = 16'd9421;
            alpha    = 131072;
            beta     = -32768;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SPEED_SCALE:       w_scale  = cfg_wr_data;
                    REG_RATIO_EXPONENT:    eta      = longint'($signed(cfg_wr_data));
                    REG_GAUSS_WIDTH:       xi       = longint'($signed(cfg_wr_data));
                    REG_DILUTION_GAIN:     dil_gain = cfg_wr_data[15:0];
                    REG_TEMP_EXPONENT:     alpha    = longint'($signed(cfg_wr_data));
                    REG_PRESSURE_EXPONENT: beta     = longint'($signed(cfg_wr_data));
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                speeds_due.push_back(flame_speed_of(s_pressure_pa, s_unburnt_temp,
                                                    s_equivalence_ratio, s_egr_fraction));
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_saturated)
                    sat_seen++;
                if (speeds_due.size() == 0) begin
                    // result beat with nothing expected
                    report_mismatch("unexpected result beat", m_flame_speed, 24'd0);
                end else begin
                    want = speeds_due.pop_front();
                    if (m_flame_speed !== want.speed)
                        report_mismatch("flame_speed", m_flame_speed, want.speed);
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", 24'(m_saturated), 24'(want.sat));
                end
            end
        end
        outstanding = speeds_due.size();
    end

endmodule

// ===== dv/tb_laminar_flame_speed_eval_top.sv =====
`timescale 1ns / 100ps

module tb_laminar_flame_speed_eval_top;
    import lfse_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles without any beat before giving up
    localparam int DRAIN_WAIT = 14;     // ten-stage pipe plus margin
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 185;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_pressure_pa;
    logic [15:0] s_unburnt_temp;
    logic [15:0] s_equivalence_ratio;
    logic [15:0] s_egr_fraction;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_flame_speed;
    logic        m_saturated;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wr_data;

    int mismatches;
    int outstanding;
    int results_seen;
    int sat_seen;
    int beats_sent;
    int settings_used;
    int burst_left;
    int idle_cycles;

    laminar_flame_speed_eval_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pressure_pa       (s_pressure_pa),
        .s_unburnt_temp      (s_unburnt_temp),
        .s_equivalence_ratio (s_equivalence_ratio),
        .s_egr_fraction      (s_egr_fraction),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_flame_speed       (m_flame_speed),
        .m_saturated         (m_saturated),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data)
    );

    // prediction and comparison live in the checker, this module only drives
    lfse_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pressure_pa       (s_pressure_pa),
        .s_unburnt_temp      (s_unburnt_temp),
        .s_equivalence_ratio (s_equivalence_ratio),
        .s_egr_fraction      (s_egr_fraction),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_flame_speed       (m_flame_speed),
        .m_saturated         (m_saturated),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .mismatches          (mismatches),
        .outstanding         (outstanding),
        .results_seen        (results_seen),
        .sat_seen            (sat_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // every input known from time zero
    initial begin
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_pressure_pa       = '0;
        s_unburnt_temp      = '0;
        s_equivalence_ratio = '0;
        s_egr_fraction      = '0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_SPEED_SCALE;
        cfg_wr_data         = '0;
        beats_sent          = 0;
        settings_used       = 1;
        burst_left          = 0;
    end

    // watchdog: counts cycles with no beat on either channel
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off so the pipe backs up
    initial begin
        int cyc;
        int mode;
        int mode_left;
        int hold_left;
        m_ready   = 1'b0;
        cyc       = 0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 1500)
                hold_left = 400;
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;                          // no stalls
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 5) < 3;           // fixed rhythm
                endcase
            end
        end
    end

    // one beat on the input channel; bursts of random length with random gaps
    task automatic send_beat(input logic [23:0] p, input logic [15:0] t,
                             input logic [15:0] phi, input logic [15:0] egr);
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid             <= 1'b1;
        s_pressure_pa       <= p;
        s_unburnt_temp      <= t;
        s_equivalence_ratio <= phi;
        s_egr_fraction      <= egr;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
    endtask

    // drop valid, let every expected beat come back, then let the pipe empty
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [23:0] scale, input logic [23:0] eta,
                              input logic [23:0] xi, input logic [23:0] gain,
                              input logic [23:0] alpha, input logic [23:0] beta);
        logic [23:0] vals [6];
        logic [2:0]  idx  [6];
        vals = '{scale, eta, xi, gain, alpha, beta};
        idx  = '{REG_SPEED_SCALE, REG_RATIO_EXPONENT, REG_GAUSS_WIDTH,
                 REG_DILUTION_GAIN, REG_TEMP_EXPONENT, REG_PRESSURE_EXPONENT};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // mostly plausible engine conditions, some raw noise with odd zeros
    task automatic send_random_beat;
        logic [23:0] p;
        logic [15:0] t;
        logic [15:0] phi;
        logic [15:0] egr;
        if ($urandom_range(0, 4) != 0) begin
            phi = 16'($urandom_range(1638, 8192));
            t   = 16'($urandom_range(250 * 16, 1000 * 16));
            p   = 24'($urandom_range(10000, 5000000));
            egr = 16'($urandom_range(0, 20000));
        end else begin
            p   = 24'($urandom);
            t   = 16'($urandom);
            phi = 16'($urandom);
            egr = 16'($urandom);
            if ($urandom_range(0, 15) == 0) p = '0;
            if ($urandom_range(0, 15) == 0) t = '0;
            if ($urandom_range(0, 15) == 0) phi = '0;
            if ($urandom_range(0, 7) == 0) egr = '0;
        end
        send_beat(p, t, phi, egr);
    endtask

    initial begin
        logic [23:0] sc;
        logic [23:0] e;
        logic [23:0] x;
        logic [23:0] f;
        logic [23:0] a;
        logic [23:0] b;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients: zero ratio, zero bases, full dilution, field extremes
        send_beat(24'd101300, 16'd4800, 16'd4096, 16'd0);
        send_beat(24'd101300, 16'd4800, 16'd0, 16'd0);        // zero ratio
        send_beat(24'd0, 16'd4800, 16'd4096, 16'd0);           // p zero, beta negative
        send_beat(24'd101300, 16'd0, 16'd4096, 16'd0);         // t zero, alpha positive
        send_beat(24'd101300, 16'd4800, 16'd4096, 16'hFFFF);   // full dilution
        send_beat(24'd101300, 16'd4800, 16'd4403, 16'd1000);   // near peak ratio
        send_beat(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(24'd1, 16'd1, 16'd1, 16'd0);
        send_beat(24'hFFFFFF, 16'hFFFF, 16'd1, 16'd0);
        send_beat(24'd1, 16'hFFFF, 16'hFFFF, 16'd1);
        drain();

        // exponents zero: zero bases give a factor of one
        write_regs(24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_beat(24'd0, 16'd0, 16'd4096, 16'hFFFF);
        send_beat(24'd0, 16'd4800, 16'hFFFF, 16'd0);
        send_beat(24'd101300, 16'd0, 16'd1, 16'd0);
        drain();

        // zero scale
        write_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_beat(24'd101300, 16'd4800, 16'd4096, 16'd0);
        send_beat(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        drain();

        // largest positive coefficients: overflow side
        write_regs(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h00FFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_beat(24'd101300, 16'd4800, 16'd4096, 16'd0);
        send_beat(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        send_beat(24'd0, 16'd0, 16'd4403, 16'd0);
        drain();

        // most negative coefficients: underflow and zero base saturation
        write_regs(24'hFFFFFF, 24'h800000, 24'h800000, 24'd0, 24'h800000, 24'h800000);
        send_beat(24'd101300, 16'd4800, 16'd4096, 16'hFFFF);
        send_beat(24'd0, 16'd4800, 16'd100, 16'd0);
        send_beat(24'd1, 16'd1, 16'hFFFF, 16'd0);
        drain();

        // random part: mostly realistic settings, a couple fully random
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 2 || ph == RANDOM_PHASES - 1) begin
                sc = 24'($urandom);
                e  = 24'($urandom);
                x  = 24'($urandom);
                f  = 24'($urandom_range(0, 65535));
                a  = 24'($urandom);
                b  = 24'($urandom);
            end else begin
                sc = 24'($urandom_range(100000, 1000000));
                e  = 24'(int'($urandom_range(0, 40000)) - 20000);
                x  = 24'(int'($urandom_range(0, 600000)) - 50000);
                f  = 24'($urandom_range(0, 20000));
                a  = 24'(int'($urandom_range(0, 200000)) - 50000);
                b  = 24'(int'($urandom_range(0, 100000)) - 80000);
            end
            write_regs(sc, e, x, f, a, b);
            repeat (ITEMS_PER_PHASE) send_random_beat();
            drain();
        end

        $display("sent %0d input beats across %0d register settings", beats_sent,
                 settings_used);
        $display("checked %0d result beats, %0d of them clipped", results_seen, sat_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lfse_pkg.sv
hw/rtl/lfse_log2.sv
hw/rtl/laminar_flame_speed_eval_top.sv
dv/lfse_checker.sv
dv/tb_laminar_flame_speed_eval_top.sv
